// ===== rtl/qppc_pkg.sv =====
// Shared types, widths and constants for the quadrature position P controller.
// No dependencies; every other file of the block uses this package.
package qppc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam int POS_W      = 32;
  localparam int TGT_W      = 32;
  localparam int TOL_W      = 10;
  localparam int GAIN_W     = 8;
  localparam int DB_W       = 9;
  localparam int SLOPE_W    = 9;
  localparam int EFF_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Error magnitude is kept saturated to this width; it covers every tolerance
  // and already drives gain * error past the PWM top for any nonzero gain.
  localparam int MAG_W = 10;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  localparam int MUL_W = 10;
  localparam int Q_SHIFT = 8;

  localparam logic [EFF_W-1:0] PWM_TOP = 9'd400;

  localparam logic [TGT_W-1:0]   TARGET_RST    = '0;
  localparam logic [TOL_W-1:0]   TOLERANCE_RST = 10'd3;
  localparam logic [GAIN_W-1:0]  GAIN_RST      = 8'd1;
  localparam logic [DB_W-1:0]    POS_DB_RST    = 9'd300;
  localparam logic [DB_W-1:0]    NEG_DB_RST    = 9'd169;
  localparam logic [SLOPE_W-1:0] POS_SLOPE_RST = 9'd64;
  localparam logic [SLOPE_W-1:0] NEG_SLOPE_RST = 9'd148;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET,
    REG_TOLERANCE,
    REG_GAIN,
    REG_POS_DB,
    REG_NEG_DB,
    REG_POS_SLOPE,
    REG_NEG_SLOPE
  } qppc_reg_t;

  typedef struct packed {
    logic signed [TGT_W-1:0] target;
    logic [TOL_W-1:0]        tolerance;
    logic [GAIN_W-1:0]       gain;
    logic [DB_W-1:0]         pos_db;
    logic [DB_W-1:0]         neg_db;
    logic [SLOPE_W-1:0]      pos_slope;
    logic [SLOPE_W-1:0]      neg_slope;
  } qppc_cfg_t;

  // One operation of the shared unit: clamp(((a * b + rnd) >> sh) + addend); rnd and sh apply only with round set
  typedef struct packed {
    logic [MUL_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_b;
    logic             round;
    logic [DB_W-1:0]  addend;
  } qppc_alu_op_t;

endpackage

// ===== rtl/qppc_if.sv =====
// Valid/ready channel interfaces: encoder sample, controller result, config write.
// Depends on qppc_pkg for field widths.
interface qppc_sample_if;
  logic valid;
  logic ready;
  logic enc_a;
  logic enc_b;
  logic clear_count;

  modport source (output valid, enc_a, enc_b, clear_count, input ready);
  modport sink (input valid, enc_a, enc_b, clear_count, output ready);
endinterface

interface qppc_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qppc_pkg::POS_W-1:0]    position;
  logic        [qppc_pkg::EFF_W-1:0]    drive_effort;
  logic                                 clockwise;
  logic                                 at_target;

  modport source (output valid, position, drive_effort, clockwise, at_target, input ready);
  modport sink (input valid, position, drive_effort, clockwise, at_target, output ready);
endinterface

interface qppc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [qppc_pkg::CFG_IDX_W-1:0]     index;
  logic [qppc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/quadrature_position_p_controller.sv =====
// Quadrature encoder counter with proportional position control.
// Depends on qppc_pkg, the channel interfaces, qppc_count, qppc_regs and qppc_alu.
//
// Each accepted sample updates the position count at once, then a sequencer
// works out the drive in four steps (error, magnitude, gain step, slope and
// deadband step) and presents the result word; the shared multiply unit serves
// the gain and slope steps in turn. The sample port is ready only while the
// block is idle, so a new sample is taken only once the result word of the
// last one has been taken. Configuration words are taken on any cycle out of
// reset and must be written while the block is idle. Neither input port is
// ready while reset is held.
module quadrature_position_p_controller #(
  parameter int COUNT_WIDTH = qppc_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  qppc_sample_if.sink   sample,
  qppc_result_if.source result,
  qppc_cfg_if.sink      cfg
);
  import qppc_pkg::*;

  localparam int ERR_W = ((COUNT_WIDTH > TGT_W) ? COUNT_WIDTH : TGT_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MAG,
    S_SCALE,
    S_MAP,
    S_SEND
  } state_t;

  state_t                  state;
  qppc_cfg_t               regs;
  logic signed [COUNT_WIDTH-1:0] count;
  logic signed [ERR_W-1:0] tgt_ext;
  logic signed [ERR_W-1:0] cnt_ext;
  logic signed [ERR_W-1:0] diff;
  logic [ERR_W-1:0]        mag_full;
  logic [MAG_W-1:0]        mag_sat;
  logic [MAG_W-1:0]        mag;
  logic                    neg;
  logic                    at;
  logic [EFF_W-1:0]        prod;
  qppc_alu_op_t            alu_op;
  logic [EFF_W-1:0]        alu_res;
  logic                    accept;

  assign sample.ready = (state == S_IDLE) && !rst;
  assign accept       = sample.valid && sample.ready;
  assign result.valid = state == S_SEND;
  assign cfg.ready    = !rst;

  qppc_count #(.COUNT_WIDTH(COUNT_WIDTH)) u_count (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .enc_a       (sample.enc_a),
    .enc_b       (sample.enc_b),
    .clear_count (sample.clear_count),
    .count       (count)
  );

  qppc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .regs     (regs)
  );

  qppc_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  always_comb begin
    tgt_ext  = ERR_W'(regs.target);
    cnt_ext  = ERR_W'(count);
    mag_full = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
    // saturate: anything past the narrow range behaves the same downstream
    mag_sat  = (|mag_full[ERR_W-1:MAG_W]) ? MAG_MAX : mag_full[MAG_W-1:0];
  end

  always_comb begin
    if (state == S_MAP) begin
      alu_op.mul_a  = MUL_W'(neg ? regs.neg_slope : regs.pos_slope);
      alu_op.mul_b  = MUL_W'(prod);
      alu_op.round  = 1'b1;
      alu_op.addend = neg ? regs.neg_db : regs.pos_db;
    end else begin
      alu_op.mul_a  = MUL_W'(regs.gain);
      alu_op.mul_b  = mag;
      alu_op.round  = 1'b0;
      alu_op.addend = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff  <= tgt_ext - cnt_ext;
          state <= S_MAG;
        end
        S_MAG: begin
          neg   <= diff[ERR_W-1];
          mag   <= mag_sat;
          at    <= mag_sat < regs.tolerance;
          state <= S_SCALE;
        end
        S_SCALE: begin
          prod  <= alu_res;
          state <= S_MAP;
        end
        S_MAP: begin
          result.position  <= POS_W'(count);
          result.at_target <= at;
          if (at || (prod == '0)) begin
            result.drive_effort <= '0;
            result.clockwise    <= 1'b1;
          end else begin
            result.drive_effort <= alu_res;
            result.clockwise    <= !neg;
          end
          state <= S_SEND;
        end
        S_SEND: begin
          if (result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(sample.ready && result.valid))
    else $error("sample taken while a result word is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample port ready right after acceptance");

  a_at_target_stops: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.at_target) |-> (result.drive_effort == '0 && result.clockwise))
    else $error("drive active while at target");

  a_effort_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.drive_effort <= PWM_TOP))
    else $error("drive effort above PWM top");
`endif

endmodule

// ===== rtl/qppc_count.sv =====
// Quadrature decoder and position counter, advanced once per accepted sample.
// Depends on qppc_pkg.
module qppc_count #(
  parameter int COUNT_WIDTH = qppc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          enc_a,
  input  logic                          enc_b,
  input  logic                          clear_count,
  output logic signed [COUNT_WIDTH-1:0] count
);
  import qppc_pkg::*;

  logic                   last_a;
  logic                   last_b;
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   edge_a;
  logic                   edge_b;
  logic                   up;
  logic                   down;

  always_comb begin
    base   = clear_count ? '0 : count;
    edge_a = enc_a != last_a;
    edge_b = enc_b != last_b;
    up     = (edge_a && (enc_a == enc_b)) || (edge_b && (enc_a != enc_b));
    down   = (edge_a && (enc_a != enc_b)) || (edge_b && (enc_a == enc_b));
    // both channels moving cancel out
    if (up && !down) begin
      count_next = base + COUNT_WIDTH'(1);
    end else if (down && !up) begin
      count_next = base - COUNT_WIDTH'(1);
    end else begin
      count_next = base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      last_a <= 1'b0;
      last_b <= 1'b0;
    end else if (step) begin
      count  <= count_next;
      last_a <= enc_a;
      last_b <= enc_b;
    end
  end

endmodule

// ===== rtl/qppc_regs.sv =====
// Configuration register file of the controller, written one word at a time.
// Depends on qppc_pkg.
module qppc_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [qppc_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [qppc_pkg::CFG_DATA_W-1:0]     wr_data,
  output qppc_pkg::qppc_cfg_t                 regs
);
  import qppc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.target    <= TARGET_RST;
      regs.tolerance <= TOLERANCE_RST;
      regs.gain      <= GAIN_RST;
      regs.pos_db    <= POS_DB_RST;
      regs.neg_db    <= NEG_DB_RST;
      regs.pos_slope <= POS_SLOPE_RST;
      regs.neg_slope <= NEG_SLOPE_RST;
    end else if (wr_en) begin
      unique case (qppc_reg_t'(wr_index))
        REG_TARGET:    regs.target    <= wr_data[TGT_W-1:0];
        REG_TOLERANCE: regs.tolerance <= wr_data[TOL_W-1:0];
        REG_GAIN:      regs.gain      <= wr_data[GAIN_W-1:0];
        REG_POS_DB:    regs.pos_db    <= wr_data[DB_W-1:0];
        REG_NEG_DB:    regs.neg_db    <= wr_data[DB_W-1:0];
        REG_POS_SLOPE: regs.pos_slope <= wr_data[SLOPE_W-1:0];
        REG_NEG_SLOPE: regs.neg_slope <= wr_data[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/qppc_alu.sv =====
// Shared multiply / round / offset / clamp unit used for both gain and slope.
// Depends on qppc_pkg.
module qppc_alu (
  input  qppc_pkg::qppc_alu_op_t          op,
  output logic [qppc_pkg::EFF_W-1:0]      res
);
  import qppc_pkg::*;

  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (Q_SHIFT - 1);

  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  rounded;
  logic [SUM_W-1:0]  scaled;
  logic [SUM_W-1:0]  total;

  always_comb begin
    prod    = op.mul_a * op.mul_b;
    rounded = SUM_W'(prod) + (op.round ? ROUND_HALF : '0);
    scaled  = op.round ? (rounded >> Q_SHIFT) : rounded;
    total   = scaled + SUM_W'(op.addend);
    res     = (total > SUM_W'(PWM_TOP)) ? PWM_TOP : total[EFF_W-1:0];
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for quadrature_position_p_controller: a directed table, then random
// encoder traffic under random settings, every result checked against its table word or an in-bench predictor.
// Depends on qppc_pkg, the channel interfaces in qppc_if.sv and the RTL top level.
module testbench;
  import qppc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 194;
  localparam int SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam longint EFFORT_CAP = longint'(PWM_TOP);

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [EFF_W-1:0]        drive_effort;
    logic                    clockwise;
    logic                    at_target;
  } drive_word_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_data;
    logic                    enc_a;
    logic                    enc_b;
    logic                    clear_count;
    logic                    typed;
    drive_word_t             word;
  } stim_row_t;

  localparam drive_word_t NO_WORD = '0;
  localparam int N_DIRECTED = 54;

  // Rows with typed set carry their expected word; the rest go to the predictor.
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b0, 1'b0, 1'b1, '{32'sd0, 9'd0, 1'b1, 1'b1}},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b1, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b1, 1'b1, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b1, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b1, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b1, 1'b0, 1'b1, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b1, 1'b1, 1'b0, NO_WORD},
    '{ROW_CFG, REG_TARGET, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_GAIN, 32'd255, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b1, 1'b1, 1'b1, '{32'sd0, 9'd400, 1'b1, 1'b0}},
    '{ROW_CFG, REG_TARGET, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b1, 1'b1, 1'b1, '{32'sd0, 9'd400, 1'b0, 1'b0}},
    '{ROW_CFG, REG_GAIN, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b1, 1'b1, 1'b1, '{32'sd0, 9'd0, 1'b1, 1'b0}},
    '{ROW_CFG, REG_TARGET, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_TOLERANCE, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_GAIN, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b1, 1'b1, 1'b1, '{32'sd0, 9'd0, 1'b1, 1'b0}},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b1, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_TARGET, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b1, 1'b1, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_TOLERANCE, 32'd1023, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b1, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_TOLERANCE, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_POS_DB, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_NEG_DB, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_POS_SLOPE, 32'd256, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_NEG_SLOPE, 32'd256, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_TARGET, 32'd100, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_POS_DB, 32'd400, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_NEG_DB, 32'd400, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_POS_SLOPE, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_NEG_SLOPE, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    // upper data bits set: only the register width is kept
    '{ROW_CFG, REG_POS_DB, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_POS_SLOPE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_GAIN, 32'hFFFF_FF03, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b1, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_TOLERANCE, 32'hFFFF_FC05, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_NEG_DB, 32'hFFFF_FE00, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_NEG_SLOPE, 32'h0000_0180, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_TARGET, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b0, 1'b1, 1'b0, NO_WORD},
    '{ROW_CFG, REG_UNMAPPED, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    // half a step of slope rounds up: effort 1 from a product of 1
    '{ROW_CFG, REG_TARGET, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_TOLERANCE, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_GAIN, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_POS_SLOPE, 32'd128, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_POS_DB, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{ROW_SAMPLE, REG_TARGET, '0, 1'b0, 1'b0, 1'b1, 1'b1, '{32'sd0, 9'd1, 1'b1, 1'b0}}
  };

  logic clk;
  logic rst;

  qppc_sample_if sample_ch ();
  qppc_result_if result_ch ();
  qppc_cfg_if    cfg_ch ();

  quadrature_position_p_controller u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Predictor copy of the settings and the counter state
  logic signed [TGT_W-1:0] set_target;
  logic [TOL_W-1:0]        set_tolerance;
  logic [GAIN_W-1:0]       set_gain;
  logic [DB_W-1:0]         set_pos_db;
  logic [DB_W-1:0]         set_neg_db;
  logic [SLOPE_W-1:0]      set_pos_slope;
  logic [SLOPE_W-1:0]      set_neg_slope;
  logic signed [POS_W-1:0] count_q;
  logic                    last_a_q;
  logic                    last_b_q;

  drive_word_t pending_drive [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic        no_gaps = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quadrature_position_p_controller verification failed");
      $finish;
    end
  end

  // Advance the counter on one sample and work out the drive word it yields.
  function automatic drive_word_t step_controller(logic a, logic b, logic clr);
    logic signed [POS_W-1:0] cnt;
    longint err, mag, prod, eff;
    logic neg;
    drive_word_t w;
    cnt = clr ? '0 : count_q;
    if (a != last_a_q) cnt = cnt + ((a == b) ? 32'sd1 : -32'sd1);
    if (b != last_b_q) cnt = cnt + ((a != b) ? 32'sd1 : -32'sd1);
    count_q = cnt;
    last_a_q = a;
    last_b_q = b;
    err = longint'(set_target) - longint'(cnt);
    neg = err < 0;
    mag = neg ? -err : err;
    w.position = cnt;
    w.drive_effort = '0;
    w.clockwise = 1'b1;
    w.at_target = 1'b0;
    if (mag < longint'(set_tolerance)) begin
      w.at_target = 1'b1;
    end else begin
      prod = longint'(set_gain) * mag;
      if (prod > EFFORT_CAP) prod = EFFORT_CAP;
      if (prod != 0) begin
        if (!neg) begin
          eff = ((longint'(set_pos_slope) * prod + (longint'(1) << (Q_SHIFT - 1)))
                 >>> Q_SHIFT) + longint'(set_pos_db);
        end else begin
          eff = ((longint'(set_neg_slope) * prod + (longint'(1) << (Q_SHIFT - 1)))
                 >>> Q_SHIFT) + longint'(set_neg_db);
          w.clockwise = 1'b0;
        end
        if (eff > EFFORT_CAP) eff = EFFORT_CAP;
        w.drive_effort = eff[EFF_W-1:0];
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, field, got, want);
  endtask

  task automatic send_sample(logic a, logic b, logic clr, logic typed,
                             drive_word_t typed_word);
    drive_word_t w;
    while (!no_gaps && $urandom_range(99) < 30) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.enc_a       <= a;
    sample_ch.enc_b       <= b;
    sample_ch.clear_count <= clr;
    do @(posedge clk); while (!sample_ch.ready);
    w = step_controller(a, b, clr);
    pending_drive.push_back(typed ? typed_word : w);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_TARGET:    set_target    = data;
      REG_TOLERANCE: set_tolerance = data[TOL_W-1:0];
      REG_GAIN:      set_gain      = data[GAIN_W-1:0];
      REG_POS_DB:    set_pos_db    = data[DB_W-1:0];
      REG_NEG_DB:    set_neg_db    = data[DB_W-1:0];
      REG_POS_SLOPE: set_pos_slope = data[SLOPE_W-1:0];
      REG_NEG_SLOPE: set_neg_slope = data[SLOPE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold samples off until every pending word is back and the block has settled.
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    result_ch.ready <= no_gaps || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin : result_check
    drive_word_t w;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_drive.size() == 0) begin
        report_mismatch("unexpected word", longint'(result_ch.position), 0);
      end else begin
        w = pending_drive.pop_front();
        if (result_ch.position !== w.position)
          report_mismatch("position", longint'($signed(result_ch.position)),
                          longint'($signed(w.position)));
        if (result_ch.drive_effort !== w.drive_effort)
          report_mismatch("drive_effort", result_ch.drive_effort, w.drive_effort);
        if (result_ch.clockwise !== w.clockwise)
          report_mismatch("clockwise", result_ch.clockwise, w.clockwise);
        if (result_ch.at_target !== w.at_target)
          report_mismatch("at_target", result_ch.at_target, w.at_target);
      end
    end
  end

  initial begin
    stim_row_t row;
    logic a, b, clr, heading;
    int r, off;
    sample_ch.valid       = 1'b0;
    sample_ch.enc_a       = 1'b0;
    sample_ch.enc_b       = 1'b0;
    sample_ch.clear_count = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_TARGET;
    cfg_ch.data           = '0;
    result_ch.ready       = 1'b0;
    rst                   = 1'b1;
    set_target    = TARGET_RST;
    set_tolerance = TOLERANCE_RST;
    set_gain      = GAIN_RST;
    set_pos_db    = POS_DB_RST;
    set_neg_db    = NEG_DB_RST;
    set_pos_slope = POS_SLOPE_RST;
    set_neg_slope = NEG_SLOPE_RST;
    count_q  = '0;
    last_a_q = 1'b0;
    last_b_q = 1'b0;
    heading  = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_CFG) begin
        drain_results();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_sample(row.enc_a, row.enc_b, row.clear_count, row.typed, row.word);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      no_gaps = (ph == 3);
      // Keep the target near the count most of the time so the error crosses tolerance
      r = $urandom_range(99);
      if (r < 70) begin
        off = int'($urandom_range(80)) - 40;
        write_reg(REG_TARGET, 32'(count_q + off));
      end else if (r < 90) begin
        off = int'($urandom_range(4000)) - 2000;
        write_reg(REG_TARGET, 32'(count_q + off));
      end else begin
        write_reg(REG_TARGET, $urandom());
      end
      r = $urandom_range(99);
      write_reg(REG_TOLERANCE, (r < 60) ? $urandom_range(8) :
                               (r < 90) ? $urandom_range(1023) : 0);
      r = $urandom_range(99);
      write_reg(REG_GAIN, (r < 50) ? $urandom_range(4, 1) :
                          (r < 80) ? $urandom_range(255) :
                          (r < 90) ? 0 : 255);
      write_reg(REG_POS_DB, ($urandom_range(9) == 0) ? $urandom_range(511)
                                                     : $urandom_range(400));
      write_reg(REG_NEG_DB, ($urandom_range(9) == 0) ? $urandom_range(511)
                                                     : $urandom_range(400));
      write_reg(REG_POS_SLOPE, ($urandom_range(9) == 0) ? $urandom_range(511)
                                                        : $urandom_range(256));
      write_reg(REG_NEG_SLOPE, ($urandom_range(9) == 0) ? $urandom_range(511)
                                                        : $urandom_range(256));
      if ($urandom_range(3) == 0) write_reg(REG_UNMAPPED, $urandom());

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(99) < 8) heading = ~heading;
        a = last_a_q;
        b = last_b_q;
        clr = 1'b0;
        r = $urandom_range(99);
        if (r < 65) begin
          // one legal quadrature step; heading high counts up
          if ((a == b) == heading) b = ~b;
          else a = ~a;
        end else if (r >= 78 && r < 86) begin
          a = ~a;
          b = ~b;
        end else if (r >= 86 && r < 92) begin
          clr = 1'b1;
          a = $urandom_range(1);
          b = $urandom_range(1);
        end else if (r >= 92) begin
          a = $urandom_range(1);
          b = $urandom_range(1);
          clr = $urandom_range(1);
        end
        send_sample(a, b, clr, 1'b0, NO_WORD);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("quadrature_position_p_controller verification clean");
    end else begin
      $display("quadrature_position_p_controller verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/qppc_pkg.sv
rtl/qppc_if.sv
rtl/qppc_count.sv
rtl/qppc_regs.sv
rtl/qppc_alu.sv
rtl/quadrature_position_p_controller.sv
tb/testbench.sv
